[src/svtd_pkg.sv]
package svtd_pkg;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

   localparam logic [1:0] CSR_LEVEL_GAIN    = 2'd0;
   localparam logic [1:0] CSR_DECAY_FACTOR  = 2'd1;
   localparam logic [1:0] CSR_RELEASE_FLOOR = 2'd2;

   localparam logic [15:0] LEVEL_GAIN_RESET    = 16'd9830;
   localparam logic [15:0] DECAY_FACTOR_RESET  = 16'd64881;
   localparam logic [15:0] RELEASE_FLOOR_RESET = 16'd328;

   localparam logic [15:0] TAIL_START  = 16'hFFFF;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [15:0] SAMPLE_MAX  = 16'd32767;

   localparam logic [63:0] SEMITONE_Q30 [12] = '{
      64'd638450708,  64'd676414963,  64'd716636690,  64'd759250125,
      64'd804397487,  64'd852229450,  64'd902905651,  64'd956595214,
      64'd1013477327, 64'd1073741824, 64'd1137589836, 64'd1205234448
   };

   // Taylor terms, innermost first: divisor, floor(2^shift / divisor), shift
   localparam int unsigned NUM_TERMS = 5;
   localparam logic [6:0]  TERM_DIV   [NUM_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] TERM_RECIP [NUM_TERMS] = '{
      32'd2498890063, 32'd3817748707, 32'd3272356035, 32'd3435973836, 32'd2863311530
   };
   localparam logic [5:0]  TERM_SHIFT [NUM_TERMS] = '{6'd38, 6'd38, 6'd37, 6'd36, 6'd34};

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  note;
      logic [15:0] velocity;
      logic        allow_tail;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               active;
   } rsp_type;

endpackage

[src/sine_voice_with_tail_decay.sv]
// Note off, unused kinds and silent ticks go from decode to the output step; note on first sets
// level, step and phase, and a sounding tick first runs the sine series, level and (in release)
// release and decay steps. No new item is taken until the last has reached the result register.
// One shared 32x32 multiplier serves the sine series (five terms) and the gain and decay steps.
// Synchronous active-high reset: voice silent, registers at defaults, no result pending.
module sine_voice_with_tail_decay #(
   parameter int SAMPLE_RATE      = 48000,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  svtd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output svtd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data
);

   localparam int DEPTH_BITS = $clog2(SINE_TABLE_DEPTH);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DECODE = 5'd1;
   localparam logic [4:0] ST_ON_LVL = 5'd2;
   localparam logic [4:0] ST_X_MUL  = 5'd3;
   localparam logic [4:0] ST_X      = 5'd4;
   localparam logic [4:0] ST_X2_MUL = 5'd5;
   localparam logic [4:0] ST_X2     = 5'd6;
   localparam logic [4:0] ST_P_MUL  = 5'd7;
   localparam logic [4:0] ST_P      = 5'd8;
   localparam logic [4:0] ST_D_MUL  = 5'd9;
   localparam logic [4:0] ST_D      = 5'd10;
   localparam logic [4:0] ST_T      = 5'd11;
   localparam logic [4:0] ST_S_MUL  = 5'd12;
   localparam logic [4:0] ST_S      = 5'd13;
   localparam logic [4:0] ST_L_MUL  = 5'd14;
   localparam logic [4:0] ST_L      = 5'd15;
   localparam logic [4:0] ST_R_MUL  = 5'd16;
   localparam logic [4:0] ST_R      = 5'd17;
   localparam logic [4:0] ST_SIGN   = 5'd18;
   localparam logic [4:0] ST_DK_MUL = 5'd19;
   localparam logic [4:0] ST_DK     = 5'd20;
   localparam logic [4:0] ST_OUT    = 5'd21;

   typedef logic [PHASE_BITS-1:0] step_table_type [128];

   function automatic step_table_type build_steps();
      step_table_type tbl;
      logic [63:0]    num;
      logic [63:0]    step;
      int             e;
      int             k;
      for (int n = 0; n < 128; n++) begin
         num = 64'd440 * svtd_pkg::SEMITONE_Q30[n % 12];
         e   = n / 12 - 35 + PHASE_BITS;
         if (e >= 0) begin
            step = ((num << e) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
         end else begin
            k    = -e;
            step = ((num + (64'(SAMPLE_RATE) << (k - 1))) >> k) / SAMPLE_RATE;
         end
         tbl[n] = step[PHASE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam step_table_type STEP_ROM = build_steps();

   function automatic logic [15:0] round_q16(input logic [31:0] prod);
      logic [32:0] sum;
      sum = {1'b0, prod} + 33'd32768;
      return sum[31:16];
   endfunction

   logic [4:0]            state_ff, state_in;
   svtd_pkg::req_type     item_ff, item_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [15:0]           level_ff, level_in;
   logic [15:0]           rf_ff, rf_in;
   logic                  releasing_ff, releasing_in;
   logic [15:0]           gain_ff, gain_in;
   logic [15:0]           decay_ff, decay_in;
   logic [15:0]           floor_ff, floor_in;
   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           x_ff, x_in;
   logic [31:0]           x2_ff, x2_in;
   logic [30:0]           t_ff, t_in;
   logic [31:0]           p_ff, p_in;
   logic [29:0]           q_ff, q_in;
   logic [2:0]            term_ff, term_in;
   logic [15:0]           mag_ff, mag_in;
   logic [15:0]           sample_ff, sample_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   svtd_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [DEPTH_BITS-1:0] sine_idx;
   logic [29:0]           r_low;
   logic [30:0]           r_fold;
   logic [31:0]           s_sum;
   logic [16:0]           s_round;
   logic [15:0]           mag_sat;
   logic [6:0]            term_div;
   logic [31:0]           rem_val;
   logic [29:0]           q_fix;
   logic [15:0]           rf_decayed;
   logic                  out_free;

   assign sine_idx   = phase_ff[PHASE_BITS-1 -: DEPTH_BITS];
   assign r_low      = {sine_idx[DEPTH_BITS-3:0], {(32 - DEPTH_BITS){1'b0}}};
   assign r_fold     = sine_idx[DEPTH_BITS-2] ? (svtd_pkg::Q30_ONE - {1'b0, r_low})
                                              : {1'b0, r_low};
   assign s_sum      = {1'b0, prod_ff[60:30]} + 32'd16384;
   assign s_round    = s_sum[31:15];
   assign mag_sat    = (mag_ff > svtd_pkg::SAMPLE_MAX) ? svtd_pkg::SAMPLE_MAX : mag_ff;
   assign term_div   = svtd_pkg::TERM_DIV[term_ff];
   assign rem_val    = p_ff - 32'({2'b00, q_ff} * {25'b0, term_div});
   assign q_fix      = q_ff + 30'(rem_val >= {25'b0, term_div});
   assign rf_decayed = round_q16(prod_ff[31:0]);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DECODE: begin
            mul_a = {16'b0, item_ff.velocity};
            mul_b = {16'b0, gain_ff};
         end
         ST_X_MUL: begin
            mul_a = x_ff;
            mul_b = svtd_pkg::HALF_PI_Q30;
         end
         ST_X2_MUL: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_P_MUL: begin
            mul_a = x2_ff;
            mul_b = {1'b0, t_ff};
         end
         ST_D_MUL: begin
            mul_a = p_ff;
            mul_b = svtd_pkg::TERM_RECIP[term_ff];
         end
         ST_S_MUL: begin
            mul_a = x_ff;
            mul_b = {1'b0, t_ff};
         end
         ST_L_MUL: begin
            mul_a = {16'b0, mag_ff};
            mul_b = {16'b0, level_ff};
         end
         ST_R_MUL: begin
            mul_a = {16'b0, mag_ff};
            mul_b = {16'b0, rf_ff};
         end
         ST_DK_MUL: begin
            mul_a = {16'b0, rf_ff};
            mul_b = {16'b0, decay_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      gain_in  = gain_ff;
      decay_in = decay_ff;
      floor_in = floor_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            svtd_pkg::CSR_LEVEL_GAIN:    gain_in  = csr_wr_data;
            svtd_pkg::CSR_DECAY_FACTOR:  decay_in = csr_wr_data;
            svtd_pkg::CSR_RELEASE_FLOOR: floor_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      rf_in        = rf_ff;
      releasing_in = releasing_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      term_in      = term_ff;
      mag_in       = mag_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            sample_in = '0;
            state_in  = ST_OUT;
            unique case (item_ff.kind)
               svtd_pkg::KIND_NOTE_ON: state_in = ST_ON_LVL;
               svtd_pkg::KIND_NOTE_OFF: begin
                  if (item_ff.allow_tail) begin
                     if (!releasing_ff) begin
                        releasing_in = 1'b1;
                        rf_in        = svtd_pkg::TAIL_START;
                     end
                  end else begin
                     step_in = '0;
                  end
               end
               svtd_pkg::KIND_TICK: begin
                  if (step_ff != '0) begin
                     x_in     = {1'b0, r_fold};
                     state_in = ST_X_MUL;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ON_LVL: begin
            level_in     = round_q16(prod_ff[31:0]);
            phase_in     = '0;
            rf_in        = '0;
            releasing_in = 1'b0;
            step_in      = STEP_ROM[item_ff.note];
            state_in     = ST_OUT;
         end
         ST_X_MUL:  state_in = ST_X;
         ST_X: begin
            x_in     = prod_ff[61:30];
            state_in = ST_X2_MUL;
         end
         ST_X2_MUL: state_in = ST_X2;
         ST_X2: begin
            x2_in    = prod_ff[61:30];
            t_in     = svtd_pkg::Q30_ONE;
            term_in  = '0;
            state_in = ST_P_MUL;
         end
         ST_P_MUL:  state_in = ST_P;
         ST_P: begin
            p_in     = prod_ff[61:30];
            state_in = ST_D_MUL;
         end
         ST_D_MUL:  state_in = ST_D;
         ST_D: begin
            q_in     = 30'(prod_ff >> svtd_pkg::TERM_SHIFT[term_ff]);
            state_in = ST_T;
         end
         ST_T: begin
            t_in = svtd_pkg::Q30_ONE - {1'b0, q_fix};
            if (term_ff == 3'(svtd_pkg::NUM_TERMS - 1)) begin
               state_in = ST_S_MUL;
            end else begin
               term_in  = term_ff + 3'd1;
               state_in = ST_P_MUL;
            end
         end
         ST_S_MUL:  state_in = ST_S;
         ST_S: begin
            mag_in   = (s_round > 17'(svtd_pkg::SAMPLE_MAX)) ? svtd_pkg::SAMPLE_MAX
                                                             : s_round[15:0];
            state_in = ST_L_MUL;
         end
         ST_L_MUL:  state_in = ST_L;
         ST_L: begin
            mag_in   = round_q16(prod_ff[31:0]);
            state_in = releasing_ff ? ST_R_MUL : ST_SIGN;
         end
         ST_R_MUL:  state_in = ST_R;
         ST_R: begin
            mag_in   = round_q16(prod_ff[31:0]);
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            sample_in = phase_ff[PHASE_BITS-1] ? (16'd0 - mag_sat) : mag_sat;
            phase_in  = phase_ff + step_ff;
            state_in  = releasing_ff ? ST_DK_MUL : ST_OUT;
         end
         ST_DK_MUL: state_in = ST_DK;
         ST_DK: begin
            if (rf_decayed <= floor_ff) begin
               step_in      = '0;
               releasing_in = 1'b0;
               rf_in        = '0;
            end else begin
               rf_in = rf_decayed;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.sample = sample_ff;
               rsp_data_in.active = (step_ff != '0);
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         level_ff     <= '0;
         rf_ff        <= '0;
         releasing_ff <= 1'b0;
         gain_ff      <= svtd_pkg::LEVEL_GAIN_RESET;
         decay_ff     <= svtd_pkg::DECAY_FACTOR_RESET;
         floor_ff     <= svtd_pkg::RELEASE_FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         rf_ff        <= rf_in;
         releasing_ff <= releasing_in;
         gain_ff      <= gain_in;
         decay_ff     <= decay_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      term_ff     <= term_in;
      mag_ff      <= mag_in;
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DECODE)
      else $error("accepted transfer not decoded");

   a_release_nonzero: assert property (@(posedge clock) disable iff (reset)
      releasing_ff |-> rf_ff != '0)
      else $error("release running with zero factor");

   a_quotient_close: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_T |-> rem_val < {24'b0, term_div, 1'b0})
      else $error("reciprocal quotient off by more than one");

endmodule

[tb/sv/voice_checker.sv]
module voice_checker
   import svtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   output int          failures,
   output int          pending,
   output int          checked
);

   localparam int RATE        = 48000;
   localparam int DEPTH       = 1024;
   localparam int PHASE_W     = 32;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint unsigned SEMITONE_RATIO [12] = '{
      64'd638450708,  64'd676414963,  64'd716636690,  64'd759250125,
      64'd804397487,  64'd852229450,  64'd902905651,  64'd956595214,
      64'd1013477327, 64'd1073741824, 64'd1137589836, 64'd1205234448
   };
   localparam longint unsigned SERIES_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   logic signed [15:0] sine_q15 [DEPTH];
   logic [31:0]        note_step [128];

   logic [15:0] gain_q16, decay_q16, floor_q16;
   logic [31:0] phase_acc, phase_inc;
   logic [15:0] level_q16, tail_factor;
   logic        in_release;

   rsp_type expected_q [$];
   int      fail_count = 0;
   int      check_count = 0;

   initial begin : build_tables
      longint unsigned u, r, x, x2, t, s, num, den;
      int e;
      for (int i = 0; i < DEPTH; i++) begin
         u = ((longint'(i) << 32) / DEPTH) & 64'hFFFF_FFFF;
         r = u & (ONE_Q30 - 1);
         if (u[30])
            r = ONE_Q30 - r;
         x  = (r * QUARTER_TURN_Q30) >> 30;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         for (int k = 0; k < 5; k++)
            t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[k];
         s = (((x * t) >> 30) + 64'd16384) >> 15;
         if (s > 64'd32767)
            s = 64'd32767;
         sine_q15[i] = u[31] ? -$signed(16'(s)) : $signed(16'(s));
      end
      for (int n = 0; n < 128; n++) begin
         num = 64'd440 * SEMITONE_RATIO[n % 12];
         e   = n / 12 - 35 + PHASE_W;
         if (e >= 0) begin
            note_step[n] = 32'(((num << e) + RATE / 2) / RATE);
         end else begin
            den = longint'(RATE) << (-e);
            note_step[n] = 32'((num + den / 2) / den);
         end
      end
   end

   function automatic logic [15:0] scale_q16(input logic [15:0] a, input logic [15:0] b);
      return 16'((32'(a) * 32'(b) + 32'd32768) >> 16);
   endfunction

   function automatic rsp_type voice_next(input req_type item);
      rsp_type            result;
      logic signed [15:0] wave;
      logic [15:0]        mag;
      logic               neg;
      logic [9:0]         idx;
      result = '0;
      case (item.kind)
         KIND_NOTE_ON: begin
            phase_acc   = '0;
            level_q16   = scale_q16(item.velocity, gain_q16);
            tail_factor = '0;
            in_release  = 1'b0;
            phase_inc   = note_step[item.note];
         end
         KIND_NOTE_OFF: begin
            if (item.allow_tail) begin
               if (!in_release) begin
                  in_release  = 1'b1;
                  tail_factor = TAIL_START;
               end
            end else begin
               phase_inc = '0;
            end
         end
         KIND_TICK: begin
            if (phase_inc != 0) begin
               idx  = 10'((64'(phase_acc) * DEPTH) >> PHASE_W);
               wave = sine_q15[idx];
               neg  = wave[15];
               mag  = neg ? 16'(-wave) : 16'(wave);
               mag  = scale_q16(mag, level_q16);
               if (in_release)
                  mag = scale_q16(mag, tail_factor);
               if (mag > SAMPLE_MAX)
                  mag = SAMPLE_MAX;
               result.sample = neg ? 16'(-mag) : mag;
               phase_acc = phase_acc + phase_inc;
               if (in_release) begin
                  tail_factor = scale_q16(tail_factor, decay_q16);
                  if (tail_factor <= floor_q16) begin
                     phase_inc   = '0;
                     in_release  = 1'b0;
                     tail_factor = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      result.active = (phase_inc != 0);
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         gain_q16    = LEVEL_GAIN_RESET;
         decay_q16   = DECAY_FACTOR_RESET;
         floor_q16   = RELEASE_FLOOR_RESET;
         phase_acc   = '0;
         phase_inc   = '0;
         level_q16   = '0;
         tail_factor = '0;
         in_release  = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEVEL_GAIN:    gain_q16  = csr_wr_data;
               CSR_DECAY_FACTOR:  decay_q16 = csr_wr_data;
               CSR_RELEASE_FLOOR: floor_q16 = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transfer, sample %0d active %0b",
                        $time, rsp_data.sample, rsp_data.active);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_count++;
               if (rsp_data.sample !== want.sample) begin
                  $display("%0t: sample mismatch, expected %0d, actual %0d",
                           $time, want.sample, rsp_data.sample);
                  fail_count++;
               end
               if (rsp_data.active !== want.active) begin
                  $display("%0t: active mismatch, expected %0b, actual %0b",
                           $time, want.active, rsp_data.active);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(voice_next(req_data));
      end
      pending  <= expected_q.size();
      failures <= fail_count;
      checked  <= check_count;
   end

endmodule

[tb/sv/testbench.sv]
module testbench;
   import svtd_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_ITEMS    = 140;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = CSR_LEVEL_GAIN;
   logic [15:0] csr_wr_data = '0;

   int           failures, pending, checked;
   idle_mix_type idle_mix       = IDLE_NONE;
   int           items_sent     = 0;
   int           settings_used  = 1;
   int           quiet_cycles   = 0;

   always #5 clock = ~clock;

   sine_voice_with_tail_decay dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   voice_checker voice_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending),
      .checked     (checked)
   );

   always @(posedge clock) begin
      case (idle_mix)
         IDLE_RECEIVER: rsp_stall <= ($urandom_range(99) < 70);
         IDLE_BOTH:     rsp_stall <= ($urandom_range(99) < 35);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic req_type make_item(input logic [1:0] kind, input logic [6:0] note,
                                         input logic [15:0] velocity, input logic tail);
      req_type item;
      item.kind       = kind;
      item.note       = note;
      item.velocity   = velocity;
      item.allow_tail = tail;
      return item;
   endfunction

   task automatic send(input req_type item);
      int gap_pct;
      gap_pct = (idle_mix == IDLE_SENDER) ? 70 : (idle_mix == IDLE_BOTH) ? 35 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.kind != KIND_UNUSED)
         items_sent++;
   endtask

   task automatic tick(input int count);
      repeat (count)
         send(make_item(KIND_TICK, 7'($urandom), 16'($urandom), 1'($urandom)));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_settings(input logic [15:0] gain, input logic [15:0] decay,
                                 input logic [15:0] floor_level);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_LEVEL_GAIN;
      csr_wr_data <= gain;
      @(posedge clock);
      csr_index   <= CSR_DECAY_FACTOR;
      csr_wr_data <= decay;
      @(posedge clock);
      csr_index   <= CSR_RELEASE_FLOOR;
      csr_wr_data <= floor_level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic play_phrase();
      int          pick;
      logic [6:0]  note;
      logic [15:0] velocity;
      pick = $urandom_range(99);
      if (pick < 8)
         send(make_item(KIND_UNUSED, 7'($urandom), 16'($urandom), 1'($urandom)));
      else if (pick < 14)
         send(make_item(KIND_NOTE_OFF, 7'($urandom), 16'($urandom), 1'($urandom)));
      case ($urandom_range(7))
         0:       velocity = 16'hFFFF;
         1:       velocity = 16'h0000;
         default: velocity = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0:       note = 7'd0;
         1:       note = 7'd127;
         default: note = 7'($urandom);
      endcase
      send(make_item(KIND_NOTE_ON, note, velocity, 1'($urandom)));
      tick($urandom_range(1, 12));
      if ($urandom_range(9) == 0) begin
         send(make_item(KIND_NOTE_ON, 7'($urandom), 16'($urandom), 1'($urandom)));
         tick($urandom_range(1, 6));
      end
      send(make_item(KIND_NOTE_OFF, 7'($urandom), 16'($urandom), $urandom_range(99) < 70));
      if ($urandom_range(4) == 0)
         send(make_item(KIND_NOTE_OFF, 7'($urandom), 16'($urandom), 1'($urandom)));
      tick($urandom_range(0, 30));
   endtask

   task automatic run_phase(input logic [15:0] gain, input logic [15:0] decay,
                            input logic [15:0] floor_level, input idle_mix_type mix);
      int target, halfway;
      bit paused;
      wait_for_results();
      write_settings(gain, decay, floor_level);
      idle_mix <= mix;
      target  = items_sent + PHASE_ITEMS;
      halfway = items_sent + PHASE_ITEMS / 2;
      paused  = 1'b0;
      while (items_sent < target) begin
         play_phrase();
         if (!paused && items_sent >= halfway) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults, silent voice corners, retrigger, release and hard stop
      send(make_item(KIND_TICK, 7'd0, 16'h0000, 1'b0));
      send(make_item(KIND_NOTE_OFF, 7'd0, 16'h0000, 1'b1));
      send(make_item(KIND_TICK, 7'd127, 16'hFFFF, 1'b1));
      send(make_item(KIND_NOTE_ON, 7'd0, 16'hFFFF, 1'b0));
      tick(2);
      send(make_item(KIND_NOTE_ON, 7'd127, 16'h0000, 1'b1));
      tick(2);
      send(make_item(KIND_NOTE_ON, 7'd69, 16'hFFFF, 1'b0));
      tick(3);
      send(make_item(KIND_NOTE_OFF, 7'd0, 16'h0000, 1'b1));
      tick(1);
      send(make_item(KIND_NOTE_OFF, 7'd0, 16'h0000, 1'b1));
      tick(1);
      send(make_item(KIND_NOTE_OFF, 7'd0, 16'h0000, 1'b0));
      tick(1);
      send(make_item(KIND_UNUSED, 7'd127, 16'hFFFF, 1'b1));

      // release that lands exactly on the floor
      wait_for_results();
      write_settings(16'hFFFF, 16'd32768, 16'd8192);
      send(make_item(KIND_NOTE_ON, 7'd60, 16'hFFFF, 1'b0));
      send(make_item(KIND_NOTE_OFF, 7'd0, 16'h0000, 1'b1));
      tick(4);

      run_phase(16'hFFFF, 16'd40000, 16'd20000, IDLE_NONE);
      run_phase(16'd0, 16'd0, 16'd0, IDLE_SENDER);
      run_phase(16'd30000, 16'hFFFF, 16'd0, IDLE_RECEIVER);
      run_phase(16'd9830, 16'd60000, 16'hFFFF, IDLE_BOTH);
      run_phase(16'($urandom), 16'($urandom_range(30000, 62000)),
                16'($urandom_range(1000, 20000)), IDLE_BOTH);
      run_phase(LEVEL_GAIN_RESET, DECAY_FACTOR_RESET, RELEASE_FLOOR_RESET, IDLE_SENDER);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d tick, note-on and note-off transfers across %0d register settings",
               items_sent, settings_used);
      $display("and four idle/stall mixes; %0d results compared.", checked);
      if (failures == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/svtd_pkg.sv
src/sine_voice_with_tail_decay.sv
tb/sv/voice_checker.sv
tb/sv/testbench.sv
